FILE: hdl/depth_pixel_to_point_stream_core_defines.svh
`ifndef DEPTH_PIXEL_TO_POINT_STREAM_CORE_DEFINES_SVH
`define DEPTH_PIXEL_TO_POINT_STREAM_CORE_DEFINES_SVH
// ----------------------------------------------------------------------------
// Depth pixel to point stream: assertion macros
// Same-cycle and next-cycle implications, disabled while reset is active.
// ----------------------------------------------------------------------------

// Check cons in the same cycle as ante.
`define DPPS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define DPPS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/dpps_pkg.sv
// ----------------------------------------------------------------------------
// dpps_pkg
// Shared constants, register indexes and saturation helpers of the depth
// pixel to point stream.
// ----------------------------------------------------------------------------
package dpps_pkg;

  // Parameter defaults
  localparam int unsigned RawDepthEntries = 2048;
  localparam int unsigned CoordBits       = 10;

  // Port widths
  localparam int unsigned PixelCoordBits = 10;
  localparam int unsigned InDataBits     = 40;
  localparam int unsigned OutDataBits    = 96;
  localparam int unsigned CfgIdxBits     = 2;
  localparam int unsigned CfgDataBits    = 24;
  localparam int unsigned RangeBits      = 24;
  localparam int unsigned PointBits      = 32;

  // Depth cache entry: valid flag over a signed Q15.16 depth
  localparam int unsigned CacheBits = PointBits + 1;

  // Depth conversion, Q28
  localparam logic [31:0] DepthAQ28 = 32'd807453852;
  localparam logic [31:0] DepthBQ28 = 32'd736855;

  // Reciprocal focal lengths, Q32
  localparam int unsigned InvKBits = 23;
  localparam logic [31:0] InvFxQ32 = 32'd7298830;
  localparam logic [31:0] InvFyQ32 = 32'd7612126;

  localparam int unsigned CenterX = 320;
  localparam int unsigned CenterY = 240;

  // Reciprocal divider: 2^44 / divisor
  localparam int unsigned DivQuoBits = 45;
  localparam int unsigned DivRemBits = 32;

  localparam int unsigned SatInBits = 48;

  // Register reset values
  localparam logic                 BigEndianRst = 1'b0;
  localparam logic [7:0]           SkipCountRst = 8'd10;
  localparam logic [RangeBits-1:0] MinRangeRst  = 24'd52429;
  localparam logic [RangeBits-1:0] MaxRangeRst  = 24'd655360;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_BIG_ENDIAN = 2'd0,
    CFG_SKIP_COUNT = 2'd1,
    CFG_MIN_RANGE  = 2'd2,
    CFG_MAX_RANGE  = 2'd3
  } cfg_idx_e;

  // Saturated signed Q15.16 value of a sign and magnitude.
  function automatic logic [PointBits-1:0] sat_val(input logic neg,
                                                   input logic [SatInBits-1:0] mag);
    logic [PointBits-1:0] res;
    if (neg) begin
      if (mag >= SatInBits'(64'h8000_0000)) begin
        res = 32'h8000_0000;
      end else begin
        res = 32'd0 - mag[PointBits-1:0];
      end
    end else begin
      if (mag > SatInBits'(64'h7FFF_FFFF)) begin
        res = 32'h7FFF_FFFF;
      end else begin
        res = mag[PointBits-1:0];
      end
    end
    return res;
  endfunction

  // Magnitude of the saturated value of a sign and magnitude.
  function automatic logic [PointBits-1:0] sat_mag(input logic neg,
                                                   input logic [SatInBits-1:0] mag);
    logic [PointBits-1:0] res;
    if (neg && mag >= SatInBits'(64'h8000_0000)) begin
      res = 32'h8000_0000;
    end else if (!neg && mag > SatInBits'(64'h7FFF_FFFF)) begin
      res = 32'h7FFF_FFFF;
    end else begin
      res = mag[PointBits-1:0];
    end
    return res;
  endfunction

endpackage

FILE: hdl/dpps_ram.sv
// ----------------------------------------------------------------------------
// dpps_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module dpps_ram #(
  parameter int unsigned WIDTH = dpps_pkg::CacheBits,
  parameter int unsigned DEPTH = dpps_pkg::RawDepthEntries
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/depth_pixel_to_point_stream_core.sv
// ----------------------------------------------------------------------------
// depth_pixel_to_point_stream_core
// Turns a stream of raw depth pixels into 3-D points (forward, leftward,
// upward; signed Q15.16 metres). One pixel in every skip_count+1 is kept, the
// counter restarting on the frame-start flag in tuser. Skipped pixels are
// taken one per cycle while no kept pixel is in work. A kept pixel whose raw
// depth code is already in the depth cache takes its depth from there; on a
// miss a one-bit-per-cycle reciprocal divider works it out first, and the rest
// of the work goes step by step through one shared 32x32 multiplier. The cache
// holds one entry per raw code (RAW_DEPTH_ENTRIES); after reset it is cleared
// in a pass over every entry during which no pixel is taken, while register
// writes are taken as always. A point is sent only if its horizontal range
// lies strictly between min_range and max_range. The output register lets
// the next pixel in while a point waits to be taken.
// ----------------------------------------------------------------------------
`include "depth_pixel_to_point_stream_core_defines.svh"

module depth_pixel_to_point_stream_core #(
  parameter int unsigned RAW_DEPTH_ENTRIES = dpps_pkg::RawDepthEntries,
  parameter int unsigned COORD_BITS        = dpps_pkg::CoordBits
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration writes
  input  logic                               cfg_we_i,
  input  logic [dpps_pkg::CfgIdxBits-1:0]    cfg_idx_i,
  input  logic [dpps_pkg::CfgDataBits-1:0]   cfg_wdata_i,
  // pixel stream
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // first_byte[7:0], second_byte[15:8], pixel_col[25:16], pixel_row[35:26]
  input  logic [dpps_pkg::InDataBits-1:0]    s_axis_tdata_i,
  // frame_start[0]
  input  logic                               s_axis_tuser_i,
  // point stream
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // forward[31:0], leftward[63:32], upward[95:64]
  output logic [dpps_pkg::OutDataBits-1:0]   m_axis_tdata_o
);

  localparam int unsigned AddrBits  = $clog2(RAW_DEPTH_ENTRIES);
  localparam int unsigned ColBits   = (COORD_BITS < dpps_pkg::PixelCoordBits) ?
                                      COORD_BITS : dpps_pkg::PixelCoordBits;
  localparam int unsigned MagBits   = ColBits;
  localparam int unsigned DiffBits  = ColBits + 2;
  localparam int unsigned TBits     = dpps_pkg::PointBits + MagBits;
  localparam int unsigned HiBits    = TBits - 16 + dpps_pkg::InvKBits;
  localparam int unsigned SumBits   = HiBits + 1;
  localparam int unsigned XmBits    = SumBits - 16;
  localparam int unsigned PB        = dpps_pkg::PointBits;
  localparam int unsigned QB        = dpps_pkg::DivQuoBits;
  localparam int unsigned RB        = dpps_pkg::DivRemBits;
  localparam int unsigned RngB      = dpps_pkg::RangeBits;
  localparam logic [15:0]         RawMask  = 16'(RAW_DEPTH_ENTRIES - 1);
  localparam logic [AddrBits-1:0] ClrLast  = AddrBits'(RAW_DEPTH_ENTRIES - 1);
  localparam logic [QB-1:0]       QuoOne   = QB'(1) << (QB - 1);
  localparam logic [5:0]          DivLast  = 6'(QB - 1);

  typedef enum logic [17:0] {
    ST_CLEAR = 18'h00001,
    ST_IDLE  = 18'h00002,
    ST_LOOK  = 18'h00004,
    ST_DEN   = 18'h00008,
    ST_DINIT = 18'h00010,
    ST_DIV   = 18'h00020,
    ST_DFIN  = 18'h00040,
    ST_TX    = 18'h00080,
    ST_HX    = 18'h00100,
    ST_LX    = 18'h00200,
    ST_TY    = 18'h00400,
    ST_HY    = 18'h00800,
    ST_LY    = 18'h01000,
    ST_SQD   = 18'h02000,
    ST_SQX   = 18'h04000,
    ST_SQLO  = 18'h08000,
    ST_SQHI  = 18'h10000,
    ST_JUDGE = 18'h20000
  } state_e;

  // control state
  state_e              state_q, state_d;
  logic [AddrBits-1:0] clr_addr_q, clr_addr_d;
  logic [5:0]          div_cnt_q, div_cnt_d;
  logic                big_endian_q, big_endian_d;
  logic [7:0]          skip_count_q, skip_count_d;
  logic [RngB-1:0]     min_range_q, min_range_d;
  logic [RngB-1:0]     max_range_q, max_range_d;
  logic [7:0]          skip_counter_q, skip_counter_d;
  logic                out_valid_q, out_valid_d;

  // datapath
  logic [AddrBits-1:0] raw_q, raw_d;
  logic [MagBits-1:0]  adx_q, adx_d, ady_q, ady_d;
  logic                dxneg_q, dxneg_d, dyneg_q, dyneg_d;
  logic [63:0]         prod_q, prod_d;
  logic                den_neg_q, den_neg_d;
  logic [RB-1:0]       ad_q, ad_d, rem_q, rem_d;
  logic [QB-1:0]       quo_q, quo_d;
  logic [PB-1:0]       depth_q, depth_d, dmag_q, dmag_d;
  logic [15:0]         t_lo_q, t_lo_d;
  logic [HiBits-1:0]   acc_q, acc_d;
  logic [XmBits-1:0]   xm_q, xm_d, ym_q, ym_d;
  logic [PB-1:0]       lw_q, lw_d, axs_q, axs_d, up_q, up_d;
  logic [62:0]         sq_q, sq_d;
  logic [63:0]         r2_q, r2_d;
  logic                lo_ok_q, lo_ok_d;
  logic [dpps_pkg::OutDataBits-1:0] out_data_q, out_data_d;

  // input decode
  logic                in_acc, keep;
  logic [7:0]          cnt_sel;
  logic [15:0]         word, raw_word;
  logic [AddrBits-1:0] in_raw;
  logic [DiffBits-1:0] dx, dy, dx_abs, dy_abs;

  // cache port
  logic                         ram_we;
  logic [AddrBits-1:0]          ram_waddr;
  logic [dpps_pkg::CacheBits-1:0] ram_wdata, ram_rdata;
  logic [PB-1:0]                hit_mag;

  // shared multiplier
  logic [PB-1:0] mul_a, mul_b;

  // divider
  logic [33:0]   den, den_abs;
  logic [RB:0]   div_r, div_sub;
  logic          div_ge;
  logic [PB-1:0] dfin_depth, dfin_mag;

  // rounding and saturation
  logic [SumBits-1:0] mul_sum;
  logic               xneg, yneg;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  assign cnt_sel  = s_axis_tuser_i ? skip_count_q : skip_counter_q;
  assign keep     = (cnt_sel == 8'd0);
  assign word     = big_endian_q ? {s_axis_tdata_i[7:0], s_axis_tdata_i[15:8]}
                                 : {s_axis_tdata_i[15:8], s_axis_tdata_i[7:0]};
  assign raw_word = word & RawMask;
  assign in_raw   = raw_word[AddrBits-1:0];

  assign dx     = {2'b00, s_axis_tdata_i[16 +: ColBits]} - DiffBits'(dpps_pkg::CenterX);
  assign dy     = {2'b00, s_axis_tdata_i[26 +: ColBits]} - DiffBits'(dpps_pkg::CenterY);
  assign dx_abs = dx[DiffBits-1] ? (DiffBits'(0) - dx) : dx;
  assign dy_abs = dy[DiffBits-1] ? (DiffBits'(0) - dy) : dy;

  assign den     = 34'(dpps_pkg::DepthAQ28) - 34'(prod_q[31:0]);
  assign den_abs = den[33] ? (34'd0 - den) : den;

  assign div_r   = {rem_q, quo_q[QB-1]};
  assign div_ge  = (div_r >= {1'b0, ad_q});
  assign div_sub = div_r - {1'b0, ad_q};

  assign dfin_depth = dpps_pkg::sat_val(den_neg_q, dpps_pkg::SatInBits'(quo_q));
  assign dfin_mag   = dpps_pkg::sat_mag(den_neg_q, dpps_pkg::SatInBits'(quo_q));

  assign hit_mag = ram_rdata[PB-1] ? (PB'(0) - ram_rdata[PB-1:0]) : ram_rdata[PB-1:0];

  assign mul_sum = SumBits'(acc_q) + SumBits'(prod_q[63:16]) + SumBits'(32768);
  assign xneg    = depth_q[PB-1] ^ dxneg_q;
  assign yneg    = !(depth_q[PB-1] ^ dyneg_q);

  assign ram_we    = (state_q == ST_CLEAR) || (state_q == ST_DFIN);
  assign ram_waddr = (state_q == ST_CLEAR) ? clr_addr_q : raw_q;
  assign ram_wdata = (state_q == ST_CLEAR) ? '0 : {1'b1, dfin_depth};

  dpps_ram #(
    .WIDTH(dpps_pkg::CacheBits),
    .DEPTH(RAW_DEPTH_ENTRIES)
  ) u_cache (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(in_raw),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    case (state_q)
      ST_DEN: begin
        mul_a = PB'(raw_q);
        mul_b = dpps_pkg::DepthBQ28;
      end
      ST_TX: begin
        mul_a = dmag_q;
        mul_b = PB'(adx_q);
      end
      ST_HX: begin
        mul_a = PB'(prod_q[TBits-1:16]);
        mul_b = dpps_pkg::InvFxQ32;
      end
      ST_LX: begin
        mul_a = PB'(t_lo_q);
        mul_b = dpps_pkg::InvFxQ32;
      end
      ST_TY: begin
        mul_a = dmag_q;
        mul_b = PB'(ady_q);
      end
      ST_HY: begin
        mul_a = PB'(prod_q[TBits-1:16]);
        mul_b = dpps_pkg::InvFyQ32;
      end
      ST_LY: begin
        mul_a = PB'(t_lo_q);
        mul_b = dpps_pkg::InvFyQ32;
      end
      ST_SQD: begin
        mul_a = dmag_q;
        mul_b = dmag_q;
      end
      ST_SQX: begin
        mul_a = axs_q;
        mul_b = axs_q;
      end
      ST_SQLO: begin
        mul_a = PB'(min_range_q);
        mul_b = PB'(min_range_q);
      end
      // hold the upper limit square while the point waits
      ST_SQHI, ST_JUDGE: begin
        mul_a = PB'(max_range_q);
        mul_b = PB'(max_range_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = 64'(mul_a) * 64'(mul_b);

  always_comb begin
    state_d        = state_q;
    clr_addr_d     = clr_addr_q;
    div_cnt_d      = div_cnt_q;
    big_endian_d   = big_endian_q;
    skip_count_d   = skip_count_q;
    min_range_d    = min_range_q;
    max_range_d    = max_range_q;
    skip_counter_d = skip_counter_q;
    out_valid_d    = out_valid_q && !m_axis_tready_i;
    raw_d          = raw_q;
    adx_d          = adx_q;
    ady_d          = ady_q;
    dxneg_d        = dxneg_q;
    dyneg_d        = dyneg_q;
    den_neg_d      = den_neg_q;
    ad_d           = ad_q;
    rem_d          = rem_q;
    quo_d          = quo_q;
    depth_d        = depth_q;
    dmag_d         = dmag_q;
    t_lo_d         = t_lo_q;
    acc_d          = acc_q;
    xm_d           = xm_q;
    ym_d           = ym_q;
    lw_d           = lw_q;
    axs_d          = axs_q;
    up_d           = up_q;
    sq_d           = sq_q;
    r2_d           = r2_q;
    lo_ok_d        = lo_ok_q;
    out_data_d     = out_data_q;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        dpps_pkg::CFG_BIG_ENDIAN: big_endian_d = cfg_wdata_i[0];
        dpps_pkg::CFG_SKIP_COUNT: skip_count_d = cfg_wdata_i[7:0];
        dpps_pkg::CFG_MIN_RANGE:  min_range_d  = cfg_wdata_i[RngB-1:0];
        dpps_pkg::CFG_MAX_RANGE:  max_range_d  = cfg_wdata_i[RngB-1:0];
        default: ;
      endcase
    end

    case (state_q)
      ST_CLEAR: begin
        clr_addr_d = clr_addr_q + AddrBits'(1);
        if (clr_addr_q == ClrLast) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          if (keep) begin
            skip_counter_d = skip_count_q;
            raw_d          = in_raw;
            adx_d          = dx_abs[MagBits-1:0];
            ady_d          = dy_abs[MagBits-1:0];
            dxneg_d        = dx[DiffBits-1];
            dyneg_d        = dy[DiffBits-1];
            state_d        = ST_LOOK;
          end else begin
            skip_counter_d = cnt_sel - 8'd1;
          end
        end
      end
      ST_LOOK: begin
        if (ram_rdata[dpps_pkg::CacheBits-1]) begin
          depth_d = ram_rdata[PB-1:0];
          dmag_d  = hit_mag;
          state_d = ST_TX;
        end else begin
          state_d = ST_DEN;
        end
      end
      ST_DEN: begin
        state_d = ST_DINIT;
      end
      ST_DINIT: begin
        den_neg_d = den[33];
        ad_d      = den_abs[RB-1:0];
        rem_d     = '0;
        quo_d     = QuoOne + QB'(den_abs[RB-1:1]);
        div_cnt_d = DivLast;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        rem_d     = div_ge ? div_sub[RB-1:0] : div_r[RB-1:0];
        quo_d     = {quo_q[QB-2:0], div_ge};
        div_cnt_d = div_cnt_q - 6'd1;
        if (div_cnt_q == 6'd0) begin
          state_d = ST_DFIN;
        end
      end
      ST_DFIN: begin
        depth_d = dfin_depth;
        dmag_d  = dfin_mag;
        state_d = ST_TX;
      end
      ST_TX: begin
        state_d = ST_HX;
      end
      ST_HX: begin
        t_lo_d  = prod_q[15:0];
        state_d = ST_LX;
      end
      ST_LX: begin
        acc_d   = prod_q[HiBits-1:0];
        state_d = ST_TY;
      end
      ST_TY: begin
        xm_d    = mul_sum[SumBits-1:16];
        state_d = ST_HY;
      end
      ST_HY: begin
        lw_d    = dpps_pkg::sat_val(!xneg && (xm_q != '0), dpps_pkg::SatInBits'(xm_q));
        axs_d   = dpps_pkg::sat_mag(xneg, dpps_pkg::SatInBits'(xm_q));
        t_lo_d  = prod_q[15:0];
        state_d = ST_LY;
      end
      ST_LY: begin
        acc_d   = prod_q[HiBits-1:0];
        state_d = ST_SQD;
      end
      ST_SQD: begin
        ym_d    = mul_sum[SumBits-1:16];
        state_d = ST_SQX;
      end
      ST_SQX: begin
        sq_d    = prod_q[62:0];
        up_d    = dpps_pkg::sat_val(yneg && (ym_q != '0), dpps_pkg::SatInBits'(ym_q));
        state_d = ST_SQLO;
      end
      ST_SQLO: begin
        r2_d    = {1'b0, sq_q} + prod_q;
        state_d = ST_SQHI;
      end
      ST_SQHI: begin
        lo_ok_d = (r2_q > prod_q);
        state_d = ST_JUDGE;
      end
      ST_JUDGE: begin
        // hold until the output register is free
        if (!out_valid_q || m_axis_tready_i) begin
          if (lo_ok_q && (r2_q < prod_q)) begin
            out_valid_d = 1'b1;
            out_data_d  = {up_q, lw_q, depth_q};
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_CLEAR;
      clr_addr_q     <= '0;
      div_cnt_q      <= '0;
      big_endian_q   <= dpps_pkg::BigEndianRst;
      skip_count_q   <= dpps_pkg::SkipCountRst;
      min_range_q    <= dpps_pkg::MinRangeRst;
      max_range_q    <= dpps_pkg::MaxRangeRst;
      skip_counter_q <= dpps_pkg::SkipCountRst;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      clr_addr_q     <= clr_addr_d;
      div_cnt_q      <= div_cnt_d;
      big_endian_q   <= big_endian_d;
      skip_count_q   <= skip_count_d;
      min_range_q    <= min_range_d;
      max_range_q    <= max_range_d;
      skip_counter_q <= skip_counter_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    raw_q      <= raw_d;
    adx_q      <= adx_d;
    ady_q      <= ady_d;
    dxneg_q    <= dxneg_d;
    dyneg_q    <= dyneg_d;
    prod_q     <= prod_d;
    den_neg_q  <= den_neg_d;
    ad_q       <= ad_d;
    rem_q      <= rem_d;
    quo_q      <= quo_d;
    depth_q    <= depth_d;
    dmag_q     <= dmag_d;
    t_lo_q     <= t_lo_d;
    acc_q      <= acc_d;
    xm_q       <= xm_d;
    ym_q       <= ym_d;
    lw_q       <= lw_d;
    axs_q      <= axs_d;
    up_q       <= up_d;
    sq_q       <= sq_d;
    r2_q       <= r2_d;
    lo_ok_q    <= lo_ok_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  `DPPS_ASSERT_IMP(a_clear_full, clk_i, rst_ni, $fell(state_q == ST_CLEAR), $past(clr_addr_q) == ClrLast, "cache clear ended early")
  `DPPS_ASSERT_IMP(a_div_rem, clk_i, rst_ni, state_q == ST_DFIN, rem_q < ad_q, "divider remainder not below divisor")
  `DPPS_ASSERT_IMP(a_dmag, clk_i, rst_ni, state_q == ST_TX, dmag_q == (depth_q[PB-1] ? PB'(0) - depth_q : depth_q), "depth magnitude mismatch")
  `DPPS_ASSERT_NXT(a_out_hold, clk_i, rst_ni, state_q == ST_JUDGE && out_valid_q && !m_axis_tready_i, state_q == ST_JUDGE, "result overran a waiting point")
  `DPPS_ASSERT_NXT(a_skip_dec, clk_i, rst_ni, in_acc && !s_axis_tuser_i && skip_counter_q != 8'd0, skip_counter_q == $past(skip_counter_q) - 8'd1, "skip counter did not advance")

endmodule

FILE: bench/depth_pixel_to_point_stream_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_pixel_to_point_stream_core_tb
// Self-checking bench for the depth pixel to point stream. Pixels are queued
// by the stimulus process and sent in random bursts. An in-bench projection
// model predicts each point from the accepted pixels and compares it field by
// field with what the block sends, while the point side stalls at random.
// The run covers directed corner pixels, skip and frame-start handling, and
// random frames under a series of register settings.
// ----------------------------------------------------------------------------
module depth_pixel_to_point_stream_core_tb;

  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [9:0] col;
    logic [9:0] row;
    logic       fs;
  } pixel_t;

  typedef struct packed {
    logic [31:0] fwd;
    logic [31:0] lft;
    logic [31:0] upw;
  } point_t;

  logic                                   clk_i = 1'b0;
  logic                                   rst_ni = 1'b0;
  logic                                   cfg_we_i = 1'b0;
  dpps_pkg::cfg_idx_e                     cfg_idx_i = dpps_pkg::CFG_BIG_ENDIAN;
  logic [dpps_pkg::CfgDataBits-1:0]       cfg_wdata_i = '0;
  logic                                   s_axis_tvalid_i = 1'b0;
  logic                                   s_axis_tready_o;
  logic [dpps_pkg::InDataBits-1:0]        s_axis_tdata_i = '0;
  logic                                   s_axis_tuser_i = 1'b0;
  logic                                   m_axis_tvalid_o;
  logic                                   m_axis_tready_i = 1'b0;
  logic [dpps_pkg::OutDataBits-1:0]       m_axis_tdata_o;

  depth_pixel_to_point_stream_core DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #6 clk_i = ~clk_i;

  // register mirror and skip state of the projection model
  logic        cfg_be   = dpps_pkg::BigEndianRst;
  logic [7:0]  cfg_skip = dpps_pkg::SkipCountRst;
  logic [23:0] cfg_min  = dpps_pkg::MinRangeRst;
  logic [23:0] cfg_max  = dpps_pkg::MaxRangeRst;
  logic [7:0]  skip_ctr = dpps_pkg::SkipCountRst;

  pixel_t pixel_q[$];
  point_t points_due[$];

  pixel_t drv_px;
  bit     drv_busy = 0;
  int     burst_left = 0;
  int     gap_left = 0;
  int     ready_run = 0;
  int     ready_hold = 0;

  int n_err = 0;
  int n_pixels = 0;
  int n_points = 0;
  int n_queued = 0;
  int n_settings = 0;

  function automatic logic [31:0] clamp_q16(input bit neg, input logic [63:0] mag);
    if (neg) begin
      return (mag >= 64'h8000_0000) ? 32'h8000_0000 : 32'(64'd0 - mag);
    end
    return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
  endfunction

  function automatic logic [63:0] mag_q16(input logic [31:0] v);
    logic [31:0] m;
    m = v[31] ? (32'd0 - v) : v;
    return {32'd0, m};
  endfunction

  // round(t * k / 2^32) on magnitudes, half up
  function automatic logic [63:0] scale_q32(input logic [63:0] t, input logic [63:0] k);
    logic [63:0] hi;
    logic [63:0] lo;
    hi = (t >> 16) * k;
    lo = (t & 64'hFFFF) * k;
    return (hi + (lo >> 16) + 64'd32768) >> 16;
  endfunction

  function automatic bit project_pixel(input pixel_t px, output point_t pt);
    logic [15:0] word;
    logic [15:0] raw;
    logic [63:0] ad, q, dmag, t, xm, ym, xsm, r2, lo2, hi2;
    logic [31:0] fw, xs;
    longint      den, dx, dy, col, row;
    bit          dneg, xneg, yneg;
    pt = '0;
    if (px.fs) skip_ctr = cfg_skip;
    if (skip_ctr != 0) begin
      skip_ctr = skip_ctr - 8'd1;
      return 0;
    end
    skip_ctr = cfg_skip;

    word = cfg_be ? {px.b0, px.b1} : {px.b1, px.b0};
    raw  = word & 16'(dpps_pkg::RawDepthEntries - 1);
    col  = longint'(px.col & 10'((1 << dpps_pkg::CoordBits) - 1));
    row  = longint'(px.row & 10'((1 << dpps_pkg::CoordBits) - 1));

    den = longint'(dpps_pkg::DepthAQ28) - longint'(dpps_pkg::DepthBQ28) * longint'(raw);
    if (den == 0) begin
      fw = 32'h7FFF_FFFF;
    end else begin
      ad = (den < 0) ? 64'(-den) : 64'(den);
      q  = ((64'd1 << 44) + (ad >> 1)) / ad;
      fw = clamp_q16(den < 0, q);
    end
    dneg = fw[31];
    dmag = mag_q16(fw);

    dx = col - longint'(dpps_pkg::CenterX);
    dy = row - longint'(dpps_pkg::CenterY);

    t    = dmag * ((dx < 0) ? 64'(-dx) : 64'(dx));
    xm   = scale_q32(t, 64'(dpps_pkg::InvFxQ32));
    xneg = dneg ^ (dx < 0);
    xs   = clamp_q16(xneg, xm);

    t    = dmag * ((dy < 0) ? 64'(-dy) : 64'(dy));
    ym   = scale_q32(t, 64'(dpps_pkg::InvFyQ32));
    yneg = (dneg == (dy < 0));

    xsm = mag_q16(xs);
    r2  = dmag * dmag + xsm * xsm;
    lo2 = 64'(cfg_min) * 64'(cfg_min);
    hi2 = 64'(cfg_max) * 64'(cfg_max);
    if (!(r2 > lo2 && r2 < hi2)) return 0;

    pt.fwd = fw;
    pt.lft = clamp_q16(!xneg && xm != 0, xm);
    pt.upw = clamp_q16(yneg && ym != 0, ym);
    return 1;
  endfunction

  // sample transactions on both streams
  always @(posedge clk_i) begin : monitor
    point_t pt;
    point_t got;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        drv_busy = 0;
        n_pixels++;
        if (project_pixel(drv_px, pt)) points_due = {points_due, pt};
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got.fwd = m_axis_tdata_o[31:0];
        got.lft = m_axis_tdata_o[63:32];
        got.upw = m_axis_tdata_o[95:64];
        n_points++;
        if (points_due.size() == 0) begin
          $error("unexpected point: forward %0d leftward %0d upward %0d",
                 $signed(got.fwd), $signed(got.lft), $signed(got.upw));
          n_err++;
        end else begin
          pt = points_due.pop_front();
          if (got.fwd !== pt.fwd) begin
            $error("forward: expected %0d, actual %0d", $signed(pt.fwd), $signed(got.fwd));
            n_err++;
          end
          if (got.lft !== pt.lft) begin
            $error("leftward: expected %0d, actual %0d", $signed(pt.lft), $signed(got.lft));
            n_err++;
          end
          if (got.upw !== pt.upw) begin
            $error("upward: expected %0d, actual %0d", $signed(pt.upw), $signed(got.upw));
            n_err++;
          end
        end
      end
    end
  end

  // drive pixels in bursts and stall the point side
  always @(negedge clk_i) begin : driver
    bit rdy;
    if (rst_ni && !drv_busy) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (pixel_q.size() > 0) begin
        drv_px = pixel_q.pop_front();
        drv_busy = 1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                   : $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
    s_axis_tvalid_i <= drv_busy;
    s_axis_tdata_i  <= {4'd0, drv_px.row, drv_px.col, drv_px.b1, drv_px.b0};
    s_axis_tuser_i  <= drv_px.fs;

    if (ready_run > 0) begin
      rdy = 1;
      ready_run--;
    end else if (ready_hold > 0) begin
      rdy = 0;
      ready_hold--;
    end else begin
      rdy = 1;
      ready_run = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150)
                                              : $urandom_range(1, 30);
      ready_hold = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(0, 4);
    end
    m_axis_tready_i <= rdy;
  end

  task automatic write_reg(input dpps_pkg::cfg_idx_e idx, input logic [23:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      dpps_pkg::CFG_BIG_ENDIAN: cfg_be   = val[0];
      dpps_pkg::CFG_SKIP_COUNT: cfg_skip = val[7:0];
      dpps_pkg::CFG_MIN_RANGE:  cfg_min  = val;
      dpps_pkg::CFG_MAX_RANGE:  cfg_max  = val;
      default: ;
    endcase
  endtask

  task automatic set_regs(input bit be, input logic [7:0] skip,
                          input logic [23:0] lo, input logic [23:0] hi);
    write_reg(dpps_pkg::CFG_BIG_ENDIAN, {23'd0, be});
    write_reg(dpps_pkg::CFG_SKIP_COUNT, {16'd0, skip});
    write_reg(dpps_pkg::CFG_MIN_RANGE, lo);
    write_reg(dpps_pkg::CFG_MAX_RANGE, hi);
    n_settings++;
  endtask

  task automatic wait_drained();
    while (pixel_q.size() != 0 || drv_busy || points_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic wait_idle();
    wait_drained();
    repeat (100) @(posedge clk_i);
  endtask

  task automatic push_px(input logic [15:0] word, input int col, input int row,
                         input bit fs);
    pixel_t px;
    if (cfg_be) {px.b0, px.b1} = word;
    else        {px.b1, px.b0} = word;
    px.col = col[9:0];
    px.row = row[9:0];
    px.fs  = fs;
    pixel_q = {pixel_q, px};
  endtask

  function automatic logic [15:0] rand_word();
    logic [10:0] raw;
    raw = ($urandom_range(0, 3) != 0) ? 11'($urandom_range(600, 1400))
                                      : 11'($urandom_range(0, 2047));
    return {5'($urandom), raw};
  endfunction

  task automatic run_frames(input int n, input int flen);
    int     cnt;
    int     len;
    int     col;
    int     row;
    pixel_t px;
    cnt = 0;
    len = 0;
    while (cnt < n) begin
      if (cnt >= n / 2 && cnt - len < n / 2 && cnt > 0) wait_drained();
      if ($urandom_range(0, 9) == 0) begin
        px = pixel_t'({5'($urandom), $urandom});
        px.b1 = 8'($urandom);
        px.fs = ($urandom_range(0, 3) == 0);
        pixel_q = {pixel_q, px};
        len = 1;
      end else begin
        len = $urandom_range(1, flen);
        if (len > n - cnt) len = n - cnt;
        col = $urandom_range(0, 1023);
        row = $urandom_range(0, 1023);
        for (int i = 0; i < len; i++) begin
          push_px(rand_word(), col, row, i == 0);
          col++;
          if (col > 1023) begin
            col = 0;
            row = (row + 1) % 1024;
          end
        end
      end
      cnt += len;
    end
    n_queued += n;
  endtask

  initial begin
    int ph;
    int n;
    int flen;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // default registers: the eleventh pixel of a frame, counting the frame-start pixel, is kept
    for (int i = 0; i < 12; i++) push_px(16'(800 + 40 * i), 300 + i, 250, i == 0);
    wait_idle();

    // every pixel kept, range limits wide open
    set_regs(1'b1, 8'd0, 24'd0, 24'hFF_FFFF);
    push_px(16'h0000, 0, 0, 1'b1);
    push_px(16'hFFFF, 1023, 1023, 1'b0);
    push_px(16'd1095, 1023, 0, 1'b0);
    push_px(16'd1096, 0, 1023, 1'b0);
    push_px(16'd800, 320, 240, 1'b0);
    push_px(16'hF800 | 16'd700, 319, 241, 1'b0);
    push_px(16'h00FF, 321, 239, 1'b0);
    wait_idle();

    // skip of two with frame starts landing mid-count
    set_regs(1'b0, 8'd2, dpps_pkg::MinRangeRst, dpps_pkg::MaxRangeRst);
    push_px(16'd900, 100, 100, 1'b1);
    push_px(16'd900, 101, 100, 1'b0);
    push_px(16'd900, 102, 100, 1'b0);
    push_px(16'd1200, 103, 100, 1'b1);
    push_px(16'd1200, 104, 100, 1'b1);
    push_px(16'd1200, 105, 100, 1'b0);
    push_px(16'd1000, 600, 400, 1'b0);
    wait_idle();

    ph = 0;
    while (n_queued < 1250 && ph < 24) begin
      n = $urandom_range(120, 200);
      flen = 64;
      case (ph % 8)
        0: set_regs(dpps_pkg::BigEndianRst, dpps_pkg::SkipCountRst,
                    dpps_pkg::MinRangeRst, dpps_pkg::MaxRangeRst);
        1: set_regs(1'b1, 8'd0, 24'($urandom_range(0, 60000)),
                    24'($urandom_range(600000, 24'hFF_FFFF)));
        2: set_regs(1'b0, 8'd1, 24'd0, 24'hFF_FFFF);
        3: begin
          set_regs(1'b1, 8'd255, 24'd0, 24'hFF_FFFF);
          n = 300;
          flen = 300;
        end
        4: set_regs(1'b0, 8'($urandom_range(2, 7)), 24'($urandom_range(0, 300000)),
                    24'($urandom_range(0, 2000000)));
        5: begin
          set_regs(1'b1, 8'd0, 24'hFF_FFFF, 24'hFF_FFFF);
          n = 40;
        end
        6: begin
          set_regs(1'b0, 8'd0, 24'd0, 24'd0);
          n = 40;
        end
        default: set_regs(1'($urandom), 8'($urandom_range(0, 3)),
                          dpps_pkg::MinRangeRst, dpps_pkg::MaxRangeRst);
      endcase
      run_frames(n, flen);
      wait_idle();
      ph++;
    end

    $display("Sent %0d pixels under %0d register settings, checked %0d points.",
             n_pixels, n_settings, n_points);
    if (n_err == 0) begin
      $display("depth_pixel_to_point_stream_core_tb: done, clean");
    end else begin
      $display("depth_pixel_to_point_stream_core_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timeout with %0d points still due.", points_due.size());
    $display("depth_pixel_to_point_stream_core_tb: done, errors");
    $finish;
  end

endmodule
